### hw/rtl/lfpd_pkg.sv
package lfpd_pkg;

  // Port widths
  localparam int SampleW  = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Control law limits
  localparam logic signed [11:0] SampleCap  = 12'sd100;
  localparam logic signed [8:0]  ErrLimit   = 9'sd30;
  localparam logic signed [24:0] LineLimit  = 25'sd150;
  localparam logic signed [15:0] MotorLimit = 16'sd255;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_DERIV_GAIN     = 3'd1,
    REG_CRUISE_SPEED   = 3'd2,
    REG_BIAS_LEFT      = 3'd3,
    REG_BIAS_CENTRE    = 3'd4,
    REG_BIAS_RIGHT     = 3'd5,
    REG_MANUAL_SPEED_A = 3'd6,
    REG_MANUAL_SPEED_B = 3'd7
  } cfg_reg_t;

  // Register file contents
  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] deriv_gain;
    logic signed [15:0] cruise_speed;
    logic signed [7:0]  bias_left;
    logic signed [7:0]  bias_centre;
    logic signed [7:0]  bias_right;
    logic signed [15:0] manual_speed_a;
    logic signed [15:0] manual_speed_b;
  } cfg_t;

  // Error stage result
  typedef struct packed {
    logic signed [5:0] err;
    logic signed [6:0] derr;
    logic              on_line;
    logic              stopped_event;
  } front_t;

  // Correction stage result
  typedef struct packed {
    logic signed [23:0] corr;
    logic               on_line;
    logic               stopped_event;
  } corr_t;

endpackage

### hw/rtl/line_follow_pd_motor_drive_core.sv
// Line-follow PD motor drive, four register stages: input, error, correction, result.
// An item passes the error, correction and result registers in turn; throughput is one
// item per cycle while out_stall is low, set by the single pass through the error,
// correction and drive stages; each stage moves whenever the one after it has room.
// Reset (rst, synchronous): pipeline empty, previous error zero, no stop reported,
// registers at their documented defaults.
module line_follow_pd_motor_drive_core
  import lfpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // sample channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SampleW-1:0]  ir_left,
  input  logic [SampleW-1:0]  ir_centre,
  input  logic [SampleW-1:0]  ir_right,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                dir_a,
  output logic                dir_b,
  output logic [7:0]          pwm_a,
  output logic [7:0]          pwm_b,
  output logic                stopped_event,
  output logic                on_line,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t               cfg;
  front_t             front;
  corr_t              corr;
  logic [SampleW-1:0] left_q, centre_q, right_q;
  logic               v_in, v_err, v_corr;
  logic               adv_in, adv_err, adv_corr, adv_out;

  assign cfg_ready = 1'b1;

  // Stage advance: a stage moves when it is empty or the next one moves
  assign adv_out  = !out_valid || !out_stall;
  assign adv_corr = !v_corr || adv_out;
  assign adv_err  = !v_err || adv_corr;
  assign adv_in   = !v_in || adv_err;
  assign in_stall = !adv_in;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in      <= 1'b0;
      v_err     <= 1'b0;
      v_corr    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_in) begin
        v_in <= in_valid;
      end
      if (adv_err) begin
        v_err <= v_in;
      end
      if (adv_corr) begin
        v_corr <= v_err;
      end
      if (adv_out) begin
        out_valid <= v_corr;
      end
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (in_valid && adv_in) begin
      left_q   <= ir_left;
      centre_q <= ir_centre;
      right_q  <= ir_right;
    end
  end

  lfpd_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lfpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .load      (v_in && adv_err),
    .ir_left   (left_q),
    .ir_centre (centre_q),
    .ir_right  (right_q),
    .cfg       (cfg),
    .res       (front)
  );

  lfpd_corr u_corr (
    .clk   (clk),
    .load  (v_err && adv_corr),
    .front (front),
    .cfg   (cfg),
    .res   (corr)
  );

  lfpd_drive u_drive (
    .clk           (clk),
    .load          (v_corr && adv_out),
    .corr          (corr),
    .cfg           (cfg),
    .dir_a         (dir_a),
    .dir_b         (dir_b),
    .pwm_a         (pwm_a),
    .pwm_b         (pwm_b),
    .stopped_event (stopped_event),
    .on_line       (on_line)
  );

endmodule

### hw/rtl/lfpd_regs.sv
module lfpd_regs
  import lfpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  // Write one register per accepted write; indexes cover the whole list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= 16'sd0;
      cfg.deriv_gain     <= 16'sd0;
      cfg.cruise_speed   <= 16'sd50;
      cfg.bias_left      <= 8'sd4;
      cfg.bias_centre    <= 8'sd0;
      cfg.bias_right     <= -8'sd3;
      cfg.manual_speed_a <= 16'sd0;
      cfg.manual_speed_b <= 16'sd0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_PROP_GAIN:      cfg.prop_gain      <= $signed(wr_data);
        REG_DERIV_GAIN:     cfg.deriv_gain     <= $signed(wr_data);
        REG_CRUISE_SPEED:   cfg.cruise_speed   <= $signed(wr_data);
        REG_BIAS_LEFT:      cfg.bias_left      <= $signed(wr_data[7:0]);
        REG_BIAS_CENTRE:    cfg.bias_centre    <= $signed(wr_data[7:0]);
        REG_BIAS_RIGHT:     cfg.bias_right     <= $signed(wr_data[7:0]);
        REG_MANUAL_SPEED_A: cfg.manual_speed_a <= $signed(wr_data);
        REG_MANUAL_SPEED_B: cfg.manual_speed_b <= $signed(wr_data);
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/lfpd_front.sv
module lfpd_front
  import lfpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [SampleW-1:0] ir_left,
  input  logic [SampleW-1:0] ir_centre,
  input  logic [SampleW-1:0] ir_right,
  input  cfg_t               cfg,
  output front_t             res
);

  logic signed [11:0] left_raw, centre_raw, right_raw;
  logic signed [11:0] left_cap, right_cap;
  logic signed [8:0]  diff;
  logic signed [5:0]  err;
  logic signed [6:0]  derr;
  logic               on_line;
  logic signed [5:0]  prev_error;
  logic               stop_reported;

  // Remove sensor bias
  assign left_raw   = $signed({2'b00, ir_left})   - $signed({{4{cfg.bias_left[7]}},   cfg.bias_left});
  assign centre_raw = $signed({2'b00, ir_centre}) - $signed({{4{cfg.bias_centre[7]}}, cfg.bias_centre});
  assign right_raw  = $signed({2'b00, ir_right})  - $signed({{4{cfg.bias_right[7]}},  cfg.bias_right});

  // Cap from above only; negative samples pass through
  assign left_cap  = (left_raw > SampleCap) ? SampleCap : left_raw;
  assign right_cap = (right_raw > SampleCap) ? SampleCap : right_raw;

  // Left minus right, clamped to the error window
  assign diff = left_cap[8:0] - right_cap[8:0];

  always_comb begin
    if (diff > ErrLimit) begin
      err = ErrLimit[5:0];
    end else if (diff < -ErrLimit) begin
      err = 6'(-ErrLimit);
    end else begin
      err = diff[5:0];
    end
  end

  assign derr    = $signed({err[5], err}) - $signed({prev_error[5], prev_error});
  assign on_line = (centre_raw >= SampleCap);

  // Track last error and off-line run state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error    <= 6'sd0;
      stop_reported <= 1'b0;
    end else if (load) begin
      prev_error    <= err;
      stop_reported <= !on_line;
    end
  end

  // Hold the stage result
  always_ff @(posedge clk) begin
    if (load) begin
      res.err           <= err;
      res.derr          <= derr;
      res.on_line       <= on_line;
      res.stopped_event <= !on_line && !stop_reported;
    end
  end

endmodule

### hw/rtl/lfpd_corr.sv
module lfpd_corr
  import lfpd_pkg::*;
(
  input  logic   clk,
  input  logic   load,
  input  front_t front,
  input  cfg_t   cfg,
  output corr_t  res
);

  logic signed [21:0] p_term;
  logic signed [22:0] d_term;
  logic signed [23:0] corr;

  // Proportional and derivative products
  assign p_term = $signed({{6{cfg.prop_gain[15]}}, cfg.prop_gain})
                * $signed({{16{front.err[5]}}, front.err});
  assign d_term = $signed({{7{cfg.deriv_gain[15]}}, cfg.deriv_gain})
                * $signed({{16{front.derr[6]}}, front.derr});
  assign corr   = $signed({{2{p_term[21]}}, p_term}) + $signed({d_term[22], d_term});

  // Hold the stage result
  always_ff @(posedge clk) begin
    if (load) begin
      res.corr          <= corr;
      res.on_line       <= front.on_line;
      res.stopped_event <= front.stopped_event;
    end
  end

endmodule

### hw/rtl/lfpd_drive.sv
module lfpd_drive
  import lfpd_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  corr_t      corr,
  input  cfg_t       cfg,
  output logic       dir_a,
  output logic       dir_b,
  output logic [7:0] pwm_a,
  output logic [7:0] pwm_b,
  output logic       stopped_event,
  output logic       on_line
);

  logic signed [24:0] line_a_raw, line_b_raw;
  logic signed [15:0] line_a, line_b;
  logic signed [15:0] speed_a, speed_b;
  logic signed [8:0]  sat_a, sat_b;
  logic [7:0]         mag_a, mag_b;

  function automatic logic signed [15:0] clamp_line(input logic signed [24:0] v);
    logic signed [24:0] c;
    begin
      c = v;
      if (v > LineLimit) begin
        c = LineLimit;
      end else if (v < -LineLimit) begin
        c = -LineLimit;
      end
      return c[15:0];
    end
  endfunction

  function automatic logic signed [8:0] clamp_motor(input logic signed [15:0] v);
    logic signed [15:0] c;
    begin
      c = v;
      if (v > MotorLimit) begin
        c = MotorLimit;
      end else if (v < -MotorLimit) begin
        c = -MotorLimit;
      end
      return c[8:0];
    end
  endfunction

  function automatic logic [7:0] magnitude(input logic signed [8:0] v);
    logic signed [8:0] m;
    begin
      m = v[8] ? -v : v;
      return m[7:0];
    end
  endfunction

  // Cruise plus and minus correction, within the line speed window
  assign line_a_raw = $signed({{9{cfg.cruise_speed[15]}}, cfg.cruise_speed})
                    + $signed({corr.corr[23], corr.corr});
  assign line_b_raw = $signed({{9{cfg.cruise_speed[15]}}, cfg.cruise_speed})
                    - $signed({corr.corr[23], corr.corr});
  assign line_a = clamp_line(line_a_raw);
  assign line_b = clamp_line(line_b_raw);

  // Fall back to manual speeds off the line
  assign speed_a = corr.on_line ? line_a : cfg.manual_speed_a;
  assign speed_b = corr.on_line ? line_b : cfg.manual_speed_b;

  assign sat_a = clamp_motor(speed_a);
  assign sat_b = clamp_motor(speed_b);
  assign mag_a = magnitude(sat_a);
  assign mag_b = magnitude(sat_b);

  // Hold the result item
  always_ff @(posedge clk) begin
    if (load) begin
      dir_a         <= !sat_a[8];
      dir_b         <= !sat_b[8];
      pwm_a         <= 8'd255 - mag_a;
      pwm_b         <= 8'd255 - mag_b;
      stopped_event <= corr.stopped_event;
      on_line       <= corr.on_line;
    end
  end

endmodule

### tb/line_follow_pd_motor_drive_core_test.sv
`timescale 1ns / 1ps

module line_follow_pd_motor_drive_core_test;
  import lfpd_pkg::*;

  // One motor drive result, in port order
  typedef struct packed {
    logic       dir_a;
    logic       dir_b;
    logic [7:0] pwm_a;
    logic [7:0] pwm_b;
    logic       stopped_event;
    logic       on_line;
  } drive_t;

  typedef enum logic {ROW_SAMPLES, ROW_REG} row_kind_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_LONG, STALL_TOGGLE} stall_mode_t;

  // Directed stimulus row: a sample set or a register write
  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    idx;
    logic [15:0] data;
    logic [9:0]  l;
    logic [9:0]  c;
    logic [9:0]  r;
    bit          known;
    drive_t      want;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [SampleW-1:0] ir_left;
  logic [SampleW-1:0] ir_centre;
  logic [SampleW-1:0] ir_right;
  logic               out_valid;
  logic               out_stall;
  logic               dir_a;
  logic               dir_b;
  logic [7:0]         pwm_a;
  logic [7:0]         pwm_b;
  logic               stopped_event;
  logic               on_line;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_reg_t           cfg_index;
  logic [15:0]        cfg_data;

  // Register copy and control state of the drive law
  cfg_t               regs_model;
  logic signed [6:0]  held_err;
  bit                 stop_flagged;

  drive_t             pending_drive[$];
  plan_row_t          plan[$];

  int unsigned        burst_left;
  int                 mismatches;
  int                 sets_sent;
  int                 writes_done;
  int                 results_seen;
  int                 online_seen;
  int                 stops_seen;

  line_follow_pd_motor_drive_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ir_left       (ir_left),
    .ir_centre     (ir_centre),
    .ir_right      (ir_right),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .dir_a         (dir_a),
    .dir_b         (dir_b),
    .pwm_a         (pwm_a),
    .pwm_b         (pwm_b),
    .stopped_event (stopped_event),
    .on_line       (on_line),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int biased_sample(logic [9:0] raw, logic signed [7:0] bias);
    int v;
    v = int'(raw) - int'(bias);
    return (v > int'(SampleCap)) ? int'(SampleCap) : v;
  endfunction

  // Saturate a speed and split it into direction and inverted drive
  function automatic logic [8:0] motor_out(int speed);
    int s;
    int mag;
    s = clip(speed, -int'(MotorLimit), int'(MotorLimit));
    mag = (s < 0) ? -s : s;
    return {(s >= 0) ? 1'b1 : 1'b0, 8'(int'(MotorLimit) - mag)};
  endfunction

  // Predict the motor drive for one sample set and advance the PD state
  function automatic drive_t compute_motor_drive(logic [9:0] il, logic [9:0] ic,
                                                 logic [9:0] ir);
    int lv;
    int cv;
    int rv;
    int err;
    int corr;
    int sa;
    int sb;
    drive_t d;
    lv = biased_sample(il, regs_model.bias_left);
    cv = biased_sample(ic, regs_model.bias_centre);
    rv = biased_sample(ir, regs_model.bias_right);
    err = clip(lv - rv, -int'(ErrLimit), int'(ErrLimit));
    corr = int'(regs_model.prop_gain) * err
         + int'(regs_model.deriv_gain) * (err - int'(held_err));
    held_err = 7'(err);
    d = '0;
    if (cv >= int'(SampleCap)) begin
      d.on_line = 1'b1;
      sa = clip(int'(regs_model.cruise_speed) + corr, -int'(LineLimit), int'(LineLimit));
      sb = clip(int'(regs_model.cruise_speed) - corr, -int'(LineLimit), int'(LineLimit));
      stop_flagged = 1'b0;
    end else begin
      // flag only the first item of an off-line run
      d.stopped_event = !stop_flagged;
      stop_flagged = 1'b1;
      sa = int'(regs_model.manual_speed_a);
      sb = int'(regs_model.manual_speed_b);
    end
    {d.dir_a, d.pwm_a} = motor_out(sa);
    {d.dir_b, d.pwm_b} = motor_out(sb);
    return d;
  endfunction

  task automatic reset_model();
    regs_model.prop_gain      = '0;
    regs_model.deriv_gain     = '0;
    regs_model.cruise_speed   = 16'sd50;
    regs_model.bias_left      = 8'sd4;
    regs_model.bias_centre    = '0;
    regs_model.bias_right     = -8'sd3;
    regs_model.manual_speed_a = '0;
    regs_model.manual_speed_b = '0;
    held_err                  = '0;
    stop_flagged              = 1'b0;
  endtask

  task automatic apply_reg(cfg_reg_t idx, logic [15:0] data);
    case (idx)
      REG_PROP_GAIN:      regs_model.prop_gain      = data;
      REG_DERIV_GAIN:     regs_model.deriv_gain     = data;
      REG_CRUISE_SPEED:   regs_model.cruise_speed   = data;
      REG_BIAS_LEFT:      regs_model.bias_left      = data[7:0];
      REG_BIAS_CENTRE:    regs_model.bias_centre    = data[7:0];
      REG_BIAS_RIGHT:     regs_model.bias_right     = data[7:0];
      REG_MANUAL_SPEED_A: regs_model.manual_speed_a = data;
      REG_MANUAL_SPEED_B: regs_model.manual_speed_b = data;
      default: ;
    endcase
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    writes_done++;
  endtask

  // Offer one sample set and hold it until accepted
  task automatic push_samples(logic [9:0] l, logic [9:0] c, logic [9:0] r,
                              bit known, drive_t want);
    drive_t predicted;
    in_valid  <= 1'b1;
    ir_left   <= l;
    ir_centre <= c;
    ir_right  <= r;
    do @(posedge clk); while (in_stall);
    predicted = compute_motor_drive(l, c, r);
    pending_drive.push_back(known ? want : predicted);
    sets_sent++;
  endtask

  // Send in bursts with random gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_drive.size() != 0);
  endtask

  function automatic plan_row_t samples_row(logic [9:0] l, logic [9:0] c, logic [9:0] r);
    plan_row_t row;
    row = '{kind: ROW_SAMPLES, idx: REG_PROP_GAIN, data: '0, l: l, c: c, r: r,
            known: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t known_row(logic [9:0] l, logic [9:0] c, logic [9:0] r,
                                          logic da, logic db, logic [7:0] pa,
                                          logic [7:0] pb, logic ev, logic on);
    plan_row_t row;
    row = samples_row(l, c, r);
    row.known = 1'b1;
    row.want = {da, db, pa, pb, ev, on};
    return row;
  endfunction

  function automatic plan_row_t reg_row(cfg_reg_t idx, logic [15:0] data);
    plan_row_t row;
    row = samples_row('0, '0, '0);
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic logic [9:0] near(int target, int spread);
    int v;
    v = target + int'($urandom_range(0, 2 * spread)) - spread;
    return 10'(clip(v, 0, 1023));
  endfunction

  // Mostly small values, sometimes the extremes
  function automatic logic [15:0] pick_value(int span);
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // Upper byte is junk that the register must ignore
  function automatic logic [15:0] pick_bias();
    logic [7:0] low;
    low = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(int'($urandom_range(0, 40)) - 20);
    return {8'($urandom), low};
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver stall pattern, switching between four modes at random
  initial begin : stall_gen
    stall_mode_t mode;
    int unsigned mode_left;
    int unsigned run_left;
    mode = STALL_NONE;
    mode_left = 0;
    run_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        STALL_LONG: begin
          if (run_left == 0) begin
            out_stall <= ~out_stall;
            run_left = out_stall ? $urandom_range(1, 6) : $urandom_range(1, 12);
          end else begin
            run_left--;
          end
        end
        default:      out_stall <= ~out_stall;
      endcase
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_result
    drive_t got;
    drive_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {dir_a, dir_b, pwm_a, pwm_b, stopped_event, on_line};
      if (pending_drive.size() == 0) begin
        $error("result with no sample set pending");
        mismatches++;
      end else begin
        want = pending_drive.pop_front();
        check_field("dir_a", 8'(want.dir_a), 8'(got.dir_a));
        check_field("dir_b", 8'(want.dir_b), 8'(got.dir_b));
        check_field("pwm_a", want.pwm_a, got.pwm_a);
        check_field("pwm_b", want.pwm_b, got.pwm_b);
        check_field("stopped_event", 8'(want.stopped_event), 8'(got.stopped_event));
        check_field("on_line", 8'(want.on_line), 8'(got.on_line));
        results_seen++;
        if (want.on_line) online_seen++;
        if (want.stopped_event) stops_seen++;
      end
    end
  end

  initial begin : stimulus
    logic [9:0] sl;
    logic [9:0] sc;
    logic [9:0] sr;
    int base;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    ir_left   <= '0;
    ir_centre <= '0;
    ir_right  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PROP_GAIN;
    cfg_data  <= '0;
    burst_left = 0;
    mismatches = 0;
    sets_sent = 0;
    writes_done = 0;
    results_seen = 0;
    online_seen = 0;
    stops_seen = 0;
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset: on line, first off-line item, rest of the run
    plan.push_back(known_row(10'd0, 10'd100, 10'd0, 1'b1, 1'b1, 8'd205, 8'd205, 1'b0, 1'b1));
    plan.push_back(known_row(10'd0, 10'd0, 10'd0, 1'b1, 1'b1, 8'd255, 8'd255, 1'b1, 1'b0));
    plan.push_back(known_row(10'd0, 10'd99, 10'd0, 1'b1, 1'b1, 8'd255, 8'd255, 1'b0, 1'b0));
    plan.push_back(samples_row(10'd1023, 10'd1023, 10'd1023));
    plan.push_back(samples_row(10'd1023, 10'd1023, 10'd0));
    // Manual speeds far past the motor limit
    plan.push_back(reg_row(REG_MANUAL_SPEED_A, 16'h7fff));
    plan.push_back(reg_row(REG_MANUAL_SPEED_B, 16'h8000));
    plan.push_back(known_row(10'd0, 10'd0, 10'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0));
    plan.push_back(samples_row(10'd1023, 10'd0, 10'd0));
    plan.push_back(reg_row(REG_MANUAL_SPEED_A, 16'hff01));
    plan.push_back(reg_row(REG_MANUAL_SPEED_B, 16'h0100));
    plan.push_back(known_row(10'd0, 10'd0, 10'd0, 1'b0, 1'b1, 8'd0, 8'd0, 1'b0, 1'b0));
    // Extreme gains and biases, negative biased samples
    plan.push_back(reg_row(REG_PROP_GAIN, 16'h7fff));
    plan.push_back(reg_row(REG_DERIV_GAIN, 16'h8000));
    plan.push_back(reg_row(REG_CRUISE_SPEED, 16'h8000));
    plan.push_back(reg_row(REG_BIAS_LEFT, 16'h5a80));
    plan.push_back(reg_row(REG_BIAS_CENTRE, 16'h007f));
    plan.push_back(reg_row(REG_BIAS_RIGHT, 16'ha57f));
    plan.push_back(samples_row(10'd1023, 10'd1023, 10'd0));
    plan.push_back(samples_row(10'd0, 10'd1023, 10'd1023));
    plan.push_back(samples_row(10'd0, 10'd226, 10'd0));
    plan.push_back(samples_row(10'd0, 10'd227, 10'd0));
    plan.push_back(reg_row(REG_PROP_GAIN, 16'h8000));
    plan.push_back(reg_row(REG_DERIV_GAIN, 16'h7fff));
    plan.push_back(reg_row(REG_CRUISE_SPEED, 16'h7fff));
    plan.push_back(reg_row(REG_BIAS_LEFT, 16'h007f));
    plan.push_back(reg_row(REG_BIAS_CENTRE, 16'h0080));
    plan.push_back(reg_row(REG_BIAS_RIGHT, 16'hff80));
    plan.push_back(reg_row(REG_MANUAL_SPEED_A, 16'hfed4));
    plan.push_back(reg_row(REG_MANUAL_SPEED_B, 16'h0000));
    plan.push_back(samples_row(10'd0, 10'd0, 10'd1023));
    plan.push_back(samples_row(10'd1023, 10'd0, 10'd0));
    plan.push_back(samples_row(10'd1023, 10'd1023, 10'd1023));
    plan.push_back(samples_row(10'd0, 10'd1023, 10'd0));
    plan.push_back(samples_row(10'd512, 10'd0, 10'd512));
    plan.push_back(reg_row(REG_BIAS_CENTRE, 16'h007f));
    plan.push_back(known_row(10'd0, 10'd0, 10'd0, 1'b0, 1'b1, 8'd0, 8'd255, 1'b1, 1'b0));
    plan.push_back(samples_row(10'd1023, 10'd1023, 10'd1023));

    // Walk the directed rows
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        cfg_valid <= 1'b0;
        push_samples(plan[i].l, plan[i].c, plan[i].r, plan[i].known, plan[i].want);
        pace();
      end
    end

    // Random phases, each with fresh register settings
    for (int p = 0; p < 9; p++) begin
      settle();
      write_reg(REG_PROP_GAIN, pick_value(8));
      write_reg(REG_DERIV_GAIN, pick_value(8));
      write_reg(REG_CRUISE_SPEED, pick_value(200));
      write_reg(REG_BIAS_LEFT, pick_bias());
      write_reg(REG_BIAS_CENTRE, pick_bias());
      write_reg(REG_BIAS_RIGHT, pick_bias());
      write_reg(REG_MANUAL_SPEED_A, pick_value(400));
      write_reg(REG_MANUAL_SPEED_B, pick_value(400));
      cfg_valid <= 1'b0;
      for (int k = 0; k < 100; k++) begin
        // hold off until the pipeline is empty, then resume
        if (k == 50) settle();
        if ($urandom_range(0, 4) == 0) begin
          sl = 10'($urandom);
          sc = 10'($urandom);
          sr = 10'($urandom);
        end else begin
          // centre around the line threshold, sides close to each other
          base = int'($urandom_range(0, 150)) - 50;
          sc = near(int'(SampleCap) + int'(regs_model.bias_centre), 12);
          sl = near(base + int'(regs_model.bias_left), 35);
          sr = near(base + int'(regs_model.bias_right), 0);
        end
        push_samples(sl, sc, sr, 1'b0, '0);
        pace();
      end
    end

    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d sample sets sent over %0d register writes; %0d results checked",
             sets_sent, writes_done, results_seen);
    $display("%0d results on the line, %0d stop events", online_seen, stops_seen);
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("line_follow_pd_motor_drive_core: match");
    end else begin
      $display("line_follow_pd_motor_drive_core: mismatch");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #5_000_000;
    $display("line_follow_pd_motor_drive_core: mismatch");
    $finish;
  end

endmodule
